@@ rtl/core/nlms_pkg.sv @@
// ----------------------------------------------------------------------------
// nlms_pkg
// Shared types and constants of the NLMS echo canceller.
// ----------------------------------------------------------------------------
`default_nettype none

package nlms_pkg;

  localparam int unsigned FILTER_TAPS = 64;
  localparam int unsigned DIV_W = 64;
  localparam logic [30:0] GAIN_RESET = 31'd50000000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIR,
    ST_OUT,
    ST_MEAN,
    ST_VAR,
    ST_VDIV,
    ST_CHK,
    ST_SDIV,
    ST_SE1,
    ST_SE2,
    ST_UPD
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/nlms_div.sv @@
// ----------------------------------------------------------------------------
// nlms_div
// Signed 64-bit divider, truncating towards zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nlms_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [nlms_pkg::DIV_W-1:0]     num,
  input  wire logic [nlms_pkg::DIV_W-1:0]     den,
  output logic                                done,
  output logic [nlms_pkg::DIV_W-1:0]          quo
);

  localparam int unsigned W = nlms_pkg::DIV_W;

  logic         busy_r;
  logic         done_r;
  logic [5:0]   cnt_r;
  logic         neg_r;
  logic [W:0]   rem_r;
  logic [W-1:0] q_r;
  logic [W-1:0] d_r;
  logic [W:0]   rem_sh;
  logic [W:0]   diff;
  logic [W-1:0] num_mag;
  logic [W-1:0] den_mag;

  always_comb begin
    num_mag = num[W-1] ? (~num + W'(1)) : num;
    den_mag = den[W-1] ? (~den + W'(1)) : den;
    rem_sh  = {rem_r[W-1:0], q_r[W-1]};
    diff    = rem_sh - {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[W-1] ^ den[W-1];
      rem_r <= '0;
      q_r   <= num_mag;
      d_r   <= den_mag;
    end else if (busy_r) begin
      rem_r <= diff[W] ? rem_sh : diff;
      q_r   <= {q_r[W-2:0], ~diff[W]};
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? (~q_r + W'(1)) : q_r;

endmodule

`default_nettype wire

@@ rtl/core/nlms_echo_canceller_top.sv @@
// ----------------------------------------------------------------------------
// nlms_echo_canceller_top
// Normalised LMS echo canceller: FIR estimate, residual, variance-normalised
// weight update. Delay line and weights sit in single-port-read memories.
//
//   channel  ports                               dir
//   in       in_valid/in_ready, ref + echo       sink
//   out      out_valid/out_ready, residual       source
//   cfg      cfg_wr_en, cfg_step_gain            sink, no wait
//
// Three passes over the taps per transfer, all through the shared
// multiplier, a step division and a division by FILTER_TAPS - 1.
// Zero variance skips the step division and the update pass. Reset is
// synchronous; memories are masked by valid bits, so there is no clearing
// pass. A stalled result holds the block after the FIR pass.
// ----------------------------------------------------------------------------
`default_nettype none

module nlms_echo_canceller_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_reference_sample,
  input  wire logic signed [15:0] in_echo_sample,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_residual_sample,
  input  wire logic               cfg_wr_en,
  input  wire logic [30:0]        cfg_step_gain
);

  localparam int unsigned AW = $clog2(nlms_pkg::FILTER_TAPS);
  localparam int unsigned CW = $clog2(nlms_pkg::FILTER_TAPS + 1);
  localparam int unsigned SW = 17 + AW;
  localparam int unsigned VW = 33 + AW;
  localparam int unsigned DW = nlms_pkg::DIV_W;
  localparam logic [AW-1:0] LAST = AW'(nlms_pkg::FILTER_TAPS - 1);
  localparam logic [CW-1:0] TAPS_C = CW'(nlms_pkg::FILTER_TAPS);

  nlms_pkg::state_t state_r, state_nxt;

  logic [30:0]          gain_r;
  logic [AW-1:0]        wp_r, head_r, ptr_r, k1_r, k2_r;
  logic [CW-1:0]        cnt_r;
  logic signed [15:0]   echo_r;
  logic                 s1_r, s2_r;
  logic [31:0]          w2_r;

  logic signed [15:0]   dl_mem [nlms_pkg::FILTER_TAPS];
  logic [31:0]          w_mem  [nlms_pkg::FILTER_TAPS];
  logic [nlms_pkg::FILTER_TAPS-1:0] dl_vld_r, w_vld_r;
  logic signed [15:0]   dl_q_r;
  logic [31:0]          w_q_r;
  logic                 dl_vq_r, w_vq_r;

  logic signed [63:0]   prod_r;
  logic [31:0]          acc_r, mean_r, step_r, se_r, e_r;
  logic signed [SW-1:0] ssum_r;
  logic signed [VW-1:0] vacc_r, var_r;
  logic                 vneg_r;
  logic [VW-1:0]        vrem_r, vquo_r;
  logic                 out_valid_r;
  logic signed [15:0]   out_res_r;

  logic                 accept, in_pass, issue, pass_end, out_free;
  logic [AW-1:0]        dl_raddr, w_raddr;
  logic signed [15:0]   x;
  logic [31:0]          w, d, e_nxt;
  logic signed [31:0]   mul_a, mul_b;
  logic                 div_start, div_done;
  logic [DW-1:0]        div_num, div_den, div_quo;
  logic [VW-1:0]        vmag, vq;
  logic                 vbig;

  assign accept   = (state_r == nlms_pkg::ST_IDLE) && in_valid;
  assign in_pass  = (state_r == nlms_pkg::ST_FIR) || (state_r == nlms_pkg::ST_VAR) ||
                    (state_r == nlms_pkg::ST_UPD);
  assign issue    = in_pass && (cnt_r != TAPS_C);
  assign pass_end = (cnt_r == TAPS_C) && !s1_r && !s2_r;
  assign out_free = !out_valid_r || out_ready;
  assign dl_raddr = (state_r == nlms_pkg::ST_VAR) ? cnt_r[AW-1:0] : ptr_r;
  assign w_raddr  = cnt_r[AW-1:0];
  assign x        = dl_vq_r ? dl_q_r : 16'sd0;
  assign w        = w_vq_r ? w_q_r : 32'd0;
  assign d        = {x, 16'h0000} - mean_r;
  assign e_nxt    = {echo_r, 16'h0000} - acc_r;

  // divide by FILTER_TAPS - 1 = 2^AW - 1: fold the high part into the low part
  assign vmag = vacc_r[VW-1] ? (~vacc_r + VW'(1)) : vacc_r;
  assign vbig = |vrem_r[VW-1:AW];
  assign vq   = vquo_r + ((vrem_r == VW'(nlms_pkg::FILTER_TAPS - 1)) ? VW'(1) : VW'(0));

  assign div_num = {1'b0, gain_r, 32'h0};
  assign div_den = {{(DW-VW-AW){var_r[VW-1]}}, var_r, {AW{1'b0}}};

  always_comb begin
    case (state_r)
      nlms_pkg::ST_VAR: begin
        mul_a = d;
        mul_b = d;
      end
      nlms_pkg::ST_FIR: begin
        mul_a = w;
        mul_b = 32'(x);
      end
      nlms_pkg::ST_UPD: begin
        mul_a = se_r;
        mul_b = 32'(x);
      end
      default: begin
        mul_a = step_r;
        mul_b = e_r;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    case (state_r)
      nlms_pkg::ST_IDLE: if (in_valid) state_nxt = nlms_pkg::ST_FIR;
      nlms_pkg::ST_FIR:  if (pass_end) state_nxt = nlms_pkg::ST_OUT;
      nlms_pkg::ST_OUT:  if (out_free) state_nxt = nlms_pkg::ST_MEAN;
      nlms_pkg::ST_MEAN: state_nxt = nlms_pkg::ST_VAR;
      nlms_pkg::ST_VAR:  if (pass_end) state_nxt = nlms_pkg::ST_VDIV;
      nlms_pkg::ST_VDIV: if (!vbig) state_nxt = nlms_pkg::ST_CHK;
      nlms_pkg::ST_CHK: begin
        if (var_r == '0) begin
          state_nxt = nlms_pkg::ST_IDLE;
        end else begin
          div_start = 1'b1;
          state_nxt = nlms_pkg::ST_SDIV;
        end
      end
      nlms_pkg::ST_SDIV: if (div_done) state_nxt = nlms_pkg::ST_SE1;
      nlms_pkg::ST_SE1:  state_nxt = nlms_pkg::ST_SE2;
      nlms_pkg::ST_SE2:  state_nxt = nlms_pkg::ST_UPD;
      nlms_pkg::ST_UPD:  if (pass_end) state_nxt = nlms_pkg::ST_IDLE;
      default:           state_nxt = nlms_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nlms_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= nlms_pkg::GAIN_RESET;
      wp_r        <= '0;
      cnt_r       <= TAPS_C;
      s1_r        <= 1'b0;
      s2_r        <= 1'b0;
      dl_vld_r    <= '0;
      w_vld_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) gain_r <= cfg_step_gain;
      s1_r <= issue;
      s2_r <= s1_r;
      if (accept) begin
        wp_r             <= (wp_r == LAST) ? '0 : wp_r + AW'(1);
        dl_vld_r[wp_r]   <= 1'b1;
        cnt_r            <= '0;
      end else if (issue) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (state_r == nlms_pkg::ST_MEAN || state_r == nlms_pkg::ST_SE2) begin
        cnt_r <= '0;
      end
      if (state_r == nlms_pkg::ST_UPD && s2_r) w_vld_r[k2_r] <= 1'b1;
      if (state_r == nlms_pkg::ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (accept) dl_mem[wp_r] <= in_reference_sample;
    if (state_r == nlms_pkg::ST_UPD && s2_r) w_mem[k2_r] <= w2_r + prod_r[46:15];
    dl_q_r  <= dl_mem[dl_raddr];
    dl_vq_r <= dl_vld_r[dl_raddr];
    w_q_r   <= w_mem[w_raddr];
    w_vq_r  <= w_vld_r[w_raddr];
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    k1_r   <= cnt_r[AW-1:0];
    k2_r   <= k1_r;
    w2_r   <= w;
    if (accept) begin
      echo_r <= in_echo_sample;
      head_r <= wp_r;
      ptr_r  <= wp_r;
      acc_r  <= '0;
      ssum_r <= '0;
    end else if (issue) begin
      ptr_r <= (ptr_r == '0) ? LAST : ptr_r - AW'(1);
    end else if (state_r == nlms_pkg::ST_SE2) begin
      ptr_r <= head_r;
    end
    if (state_r == nlms_pkg::ST_FIR && s1_r) ssum_r <= ssum_r + SW'(x);
    if (state_r == nlms_pkg::ST_FIR && s2_r) acc_r <= acc_r + prod_r[46:15];
    if (state_r == nlms_pkg::ST_OUT && out_free) begin
      e_r       <= e_nxt;
      out_res_r <= e_nxt[31:16];
    end
    // sum * 2^16 / FILTER_TAPS is exact, so the mean is a shift
    if (state_r == nlms_pkg::ST_MEAN) begin
      mean_r <= {ssum_r[SW-2:0], {(16-AW){1'b0}}};
      vacc_r <= '0;
    end
    if (state_r == nlms_pkg::ST_VAR && s2_r) begin
      vacc_r <= vacc_r + {{(VW-32){prod_r[62]}}, prod_r[62:31]};
    end
    if (state_r == nlms_pkg::ST_VAR && pass_end) begin
      vneg_r <= vacc_r[VW-1];
      vrem_r <= vmag;
      vquo_r <= '0;
    end
    if (state_r == nlms_pkg::ST_VDIV) begin
      if (vbig) begin
        vquo_r <= vquo_r + VW'(vrem_r[VW-1:AW]);
        vrem_r <= VW'(vrem_r[AW-1:0]) + VW'(vrem_r[VW-1:AW]);
      end else begin
        var_r <= vneg_r ? (~vq + VW'(1)) : vq;
      end
    end
    if (state_r == nlms_pkg::ST_SDIV && div_done) step_r <= div_quo[31:0];
    if (state_r == nlms_pkg::ST_SE2) se_r <= prod_r[62:31];
  end

  nlms_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign in_ready            = (state_r == nlms_pkg::ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_residual_sample = out_res_r;

endmodule

`default_nettype wire

@@ rtl/core/nlms_chk.sv @@
// ----------------------------------------------------------------------------
// nlms_chk
// Port-level checks of the echo canceller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nlms_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic signed [15:0] in_reference_sample,
  input wire logic signed [15:0] in_echo_sample,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [15:0] out_residual_sample,
  input wire logic               cfg_wr_en,
  input wire logic [30:0]        cfg_step_gain
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_residual_sample))
    else $error("result dropped or changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while one is in work");

  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result shown in the cycle after a transfer");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("result or busy state survives reset");

endmodule

bind nlms_echo_canceller_top nlms_chk u_nlms_chk (.*);

`default_nettype wire
